/* rtl/psth_pkg.sv */
// Shared types and constants of the peri-stimulus time histogram accumulator.
package psth_pkg;
  localparam int unsigned NumChannels   = 32;
  localparam int unsigned NumUnits      = 4;
  localparam int unsigned NumConditions = 16;
  localparam int unsigned MaxBins       = 64;
  localparam int unsigned ChW  = 5;
  localparam int unsigned UnW  = 2;
  localparam int unsigned ClW  = 4;
  localparam int unsigned BinW = 6;
  localparam int unsigned AddrW = ChW + UnW + ClW + BinW;
  localparam logic [15:0] Sat16 = 16'hFFFF;

  typedef enum logic [2:0] {
    ActClear = 3'd0, ActAddCond = 3'd1, ActStart = 3'd2, ActAlign = 3'd3,
    ActEnd = 3'd4, ActSpike = 3'd5, ActRead = 3'd6, ActZero = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    StOk = 3'd0, StNoTrial = 3'd1, StOutside = 3'd2, StUnreg = 3'd3,
    StFull = 3'd4, StRange = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    SIdle, SSweep, SDiv, SRead, SWrite, SDone
  } state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [11:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage

/* rtl/psth_div.sv */
// Restoring divider, one quotient bit per cycle.
module psth_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psth_pkg::div_req_t req_i,
  output psth_pkg::div_rsp_t rsp_o
);
  logic [31:0] quo_q, quo_d;
  logic [11:0] rem_q, rem_d;
  logic [11:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [12:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    trial = {rem_q, quo_q[31]};
    if (req_i.start) begin
      quo_d = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
      cnt_d = 6'd32;
    end else if (cnt_q != 6'd0) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 12'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        // remainder stays below the divisor, so the top bit is zero here
        rem_d = trial[11:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = (cnt_q != 6'd0);
  assign rsp_o.quotient = quo_q;
endmodule

/* rtl/psth_accumulator.sv */
// Peri-stimulus time histogram accumulator: control sequencer and count memory.
// One word at a time. A spike that passes its trial checks runs the 32-step serial
// divider for its bin, then a read-modify-write of the count memory unless the bin
// falls outside. Clear and zero sweep all 131072 count words, one per cycle, and the
// block also runs that sweep after reset, so it accepts no word until that sweep is
// done. Result words wait in an output register; the next word is taken meanwhile
// and the sequencer holds at its end until that register is free.
module psth_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] event_time, [35:32] condition_index, [40:36] channel_index,
  // [42:41] unit_index, [48:43] bin_index, zero fill
  input  logic [55:0] s_axis_tdata,
  // action
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [18:3] bin_value, [34:19] class_trials_out,
  // [50:35] total_trials_out, [54:51] new_condition, zero fill
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [11:0] cfg_wdata_i
);
  localparam int unsigned AW = psth_pkg::AddrW;

  psth_pkg::state_e state_q, state_d;

  logic [11:0] bin_width_q;
  logic [6:0]  bins_in_use_q;

  logic [psth_pkg::NumConditions-1:0] reg_q, reg_d;
  logic [15:0] ctr_q [psth_pkg::NumConditions];
  logic [15:0] ctr_d [psth_pkg::NumConditions];
  logic [4:0]  used_q, used_d;
  logic [15:0] total_q, total_d;
  logic [3:0]  cur_q, cur_d;
  logic        cvalid_q, cvalid_d, svalid_q, svalid_d, intr_q, intr_d;
  logic [31:0] tstart_q, tstart_d;

  logic [31:0] t_q, t_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] sweep_q, sweep_d;
  logic        rd_ret_q, rd_ret_d;

  logic        ov_q, ov_d;
  logic [55:0] out_q, out_d;
  logic [2:0]  st_q, st_d;
  logic [15:0] val_q, val_d;
  logic [15:0] ct_q, ct_d;
  logic [3:0]  nc_q, nc_d;

  logic [15:0] mem [2**AW];
  logic [15:0] rdata_q;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0] mem_wdata;

  psth_pkg::div_req_t div_req;
  psth_pkg::div_rsp_t div_rsp;

  psth_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));

  logic [31:0] ev_t;
  logic [3:0]  ev_cl;
  logic [4:0]  ev_ch;
  logic [1:0]  ev_un;
  logic [5:0]  ev_bin;
  logic [6:0]  blim;
  logic        accept;

  assign ev_t   = s_axis_tdata[31:0];
  assign ev_cl  = s_axis_tdata[35:32];
  assign ev_ch  = s_axis_tdata[40:36];
  assign ev_un  = s_axis_tdata[42:41];
  assign ev_bin = s_axis_tdata[48:43];
  assign blim   = (bins_in_use_q > 7'(psth_pkg::MaxBins)) ? 7'(psth_pkg::MaxBins)
                                                          : bins_in_use_q;
  assign s_axis_tready = (state_q == psth_pkg::SIdle);
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    reg_d = reg_q;
    ctr_d = ctr_q;
    used_d = used_q;
    total_d = total_q;
    cur_d = cur_q;
    cvalid_d = cvalid_q;
    svalid_d = svalid_q;
    intr_d = intr_q;
    tstart_d = tstart_q;
    t_d = t_q;
    addr_d = addr_q;
    sweep_d = sweep_q;
    rd_ret_d = rd_ret_q;
    ov_d = ov_q;
    out_d = out_q;
    st_d = st_q;
    val_d = val_q;
    ct_d = ct_q;
    nc_d = nc_q;
    mem_we = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    div_req.start = 1'b0;
    div_req.dividend = t_q - tstart_q;
    div_req.divisor = (bin_width_q == 12'd0) ? 12'd1 : bin_width_q;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    case (state_q)
      psth_pkg::SIdle: begin
        if (accept) begin
          st_d = psth_pkg::StOk;
          val_d = '0;
          ct_d = '0;
          nc_d = '0;
          t_d = ev_t;
          case (psth_pkg::action_e'(s_axis_tuser))
            psth_pkg::ActClear: begin
              reg_d = '0;
              for (int i = 0; i < psth_pkg::NumConditions; i++) ctr_d[i] = '0;
              used_d = '0;
              total_d = '0;
              cur_d = '0;
              cvalid_d = 1'b0;
              svalid_d = 1'b0;
              intr_d = 1'b0;
              tstart_d = '0;
              sweep_d = '0;
              rd_ret_d = 1'b1;
              state_d = psth_pkg::SSweep;
            end
            psth_pkg::ActZero: begin
              for (int i = 0; i < psth_pkg::NumConditions; i++) ctr_d[i] = '0;
              total_d = '0;
              sweep_d = '0;
              rd_ret_d = 1'b1;
              state_d = psth_pkg::SSweep;
            end
            psth_pkg::ActAddCond: begin
              if (used_q >= 5'(psth_pkg::NumConditions)) begin
                st_d = psth_pkg::StFull;
              end else begin
                nc_d = used_q[3:0];
                reg_d[used_q[3:0]] = 1'b1;
                ctr_d[used_q[3:0]] = '0;
                used_d = used_q + 5'd1;
              end
              state_d = psth_pkg::SDone;
            end
            psth_pkg::ActStart: begin
              if (!reg_q[ev_cl]) begin
                st_d = psth_pkg::StUnreg;
                ct_d = ctr_q[ev_cl];
              end else begin
                cur_d = ev_cl;
                cvalid_d = 1'b1;
                if (total_q != psth_pkg::Sat16) total_d = total_q + 16'd1;
                if (ctr_q[ev_cl] != psth_pkg::Sat16) begin
                  ctr_d[ev_cl] = ctr_q[ev_cl] + 16'd1;
                  ct_d = ctr_q[ev_cl] + 16'd1;
                end else begin
                  ct_d = ctr_q[ev_cl];
                end
              end
              state_d = psth_pkg::SDone;
            end
            psth_pkg::ActAlign: begin
              tstart_d = ev_t;
              svalid_d = 1'b1;
              intr_d = 1'b1;
              state_d = psth_pkg::SDone;
            end
            psth_pkg::ActEnd: begin
              intr_d = 1'b0;
              cvalid_d = 1'b0;
              svalid_d = 1'b0;
              state_d = psth_pkg::SDone;
            end
            psth_pkg::ActSpike: begin
              state_d = psth_pkg::SDone;
              if (!intr_q || !cvalid_q || !svalid_q) begin
                st_d = psth_pkg::StNoTrial;
              end else begin
                ct_d = ctr_q[cur_q];
                if (!reg_q[cur_q]) begin
                  st_d = psth_pkg::StUnreg;
                end else if (ev_t < tstart_q) begin
                  st_d = psth_pkg::StOutside;
                end else begin
                  addr_d = {ev_ch, ev_un, cur_q, 6'd0};
                  state_d = psth_pkg::SDiv;
                  rd_ret_d = 1'b0;
                end
              end
            end
            psth_pkg::ActRead: begin
              ct_d = ctr_q[ev_cl];
              state_d = psth_pkg::SDone;
              if (!reg_q[ev_cl]) begin
                st_d = psth_pkg::StUnreg;
              end else if ({1'b0, ev_bin} >= blim) begin
                st_d = psth_pkg::StOutside;
              end else begin
                addr_d = {ev_ch, ev_un, ev_cl, ev_bin};
                state_d = psth_pkg::SRead;
                rd_ret_d = 1'b1;
              end
            end
            default: state_d = psth_pkg::SDone;
          endcase
        end
      end
      psth_pkg::SSweep: begin
        mem_we = 1'b1;
        mem_waddr = sweep_q;
        sweep_d = sweep_q + 1'b1;
        if (&sweep_q) state_d = rd_ret_q ? psth_pkg::SDone : psth_pkg::SIdle;
      end
      psth_pkg::SDiv: begin
        if (!rd_ret_q) begin
          div_req.start = 1'b1;
          rd_ret_d = 1'b1;
        end else if (!div_rsp.busy) begin
          if (div_rsp.quotient >= {25'd0, blim}) begin
            st_d = psth_pkg::StOutside;
            state_d = psth_pkg::SDone;
          end else begin
            addr_d = {addr_q[AW-1:6], div_rsp.quotient[5:0]};
            rd_ret_d = 1'b0;
            state_d = psth_pkg::SRead;
          end
        end
      end
      psth_pkg::SRead: begin
        state_d = psth_pkg::SWrite;
      end
      psth_pkg::SWrite: begin
        if (rd_ret_q) begin
          val_d = rdata_q;
        end else begin
          mem_we = (rdata_q != psth_pkg::Sat16);
          mem_wdata = rdata_q + 16'd1;
        end
        state_d = psth_pkg::SDone;
      end
      psth_pkg::SDone: begin
        // hold until the output register is empty or drains this cycle
        if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1;
          out_d = {1'b0, nc_q, total_q, ct_q, val_q, st_q};
          state_d = psth_pkg::SIdle;
        end
      end
      default: state_d = psth_pkg::SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psth_pkg::SSweep;
      bin_width_q <= 12'd10;
      bins_in_use_q <= 7'd50;
      reg_q <= '0;
      for (int i = 0; i < psth_pkg::NumConditions; i++) ctr_q[i] <= '0;
      used_q <= '0;
      total_q <= '0;
      cur_q <= '0;
      cvalid_q <= 1'b0;
      svalid_q <= 1'b0;
      intr_q <= 1'b0;
      tstart_q <= '0;
      sweep_q <= '0;
      rd_ret_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && !cfg_addr_i) bin_width_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_addr_i) bins_in_use_q <= cfg_wdata_i[6:0];
      reg_q <= reg_d;
      ctr_q <= ctr_d;
      used_q <= used_d;
      total_q <= total_d;
      cur_q <= cur_d;
      cvalid_q <= cvalid_d;
      svalid_q <= svalid_d;
      intr_q <= intr_d;
      tstart_q <= tstart_d;
      sweep_q <= sweep_d;
      rd_ret_q <= rd_ret_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    addr_q <= addr_d;
    st_q <= st_d;
    val_q <= val_d;
    ct_q <= ct_d;
    nc_q <= nc_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[addr_q];
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = out_q;
endmodule

/* rtl/psth_checker.sv */
// Port-level checks for the histogram accumulator, bound to the top level.
module psth_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after take");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd5) else $error("bad status");
  a_read_only_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] != 3'd0 |-> m_axis_tdata[18:3] == 16'd0)
    else $error("value on failed action");
endmodule

bind psth_accumulator psth_checker u_psth_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

/* sim/psth_accumulator_test.sv */
// Testbench for the peri-stimulus time histogram accumulator: random trials vs. a predictor.
`timescale 1ns / 1ps

module psth_accumulator_test;

  typedef struct {
    psth_pkg::action_e act;
    logic [31:0] t;
    logic [3:0]  cl;
    logic [4:0]  ch;
    logic [1:0]  un;
    logic [5:0]  b;
  } event_word_t;

  typedef struct {
    psth_pkg::status_e status;
    logic [15:0] value;
    logic [15:0] ctrials;
    logic [15:0] total;
    logic [3:0]  newc;
  } psth_result_t;

  class histogram_model;
    logic [11:0]  bin_width = 12'd10;
    logic [6:0]   bins_in_use = 7'd50;
    int unsigned  counts[int unsigned];
    bit           registered[psth_pkg::NumConditions];
    logic [15:0]  class_trials[psth_pkg::NumConditions];
    int unsigned  used;
    logic [15:0]  total;
    logic [3:0]   cur;
    bit           class_ok, start_ok, in_trial;
    logic [31:0]  start;
    psth_result_t pending_results[$];
    int unsigned  hit_cells[$];
    int           errors;

    function new();
      clear_all();
      errors = 0;
    endfunction

    function void clear_all();
      counts.delete();
      hit_cells.delete();
      foreach (registered[i]) begin
        registered[i] = 0;
        class_trials[i] = '0;
      end
      used = 0;
      total = '0;
      cur = '0;
      class_ok = 0;
      start_ok = 0;
      in_trial = 0;
      start = '0;
    endfunction

    function int unsigned bin_limit();
      return (bins_in_use > psth_pkg::MaxBins) ? psth_pkg::MaxBins : bins_in_use;
    endfunction

    function void note_word(event_word_t w);
      psth_result_t r;
      int unsigned  key, wd;
      logic [31:0]  bin;
      r = '{psth_pkg::StOk, 16'd0, 16'd0, 16'd0, 4'd0};
      case (w.act)
        psth_pkg::ActClear: clear_all();
        psth_pkg::ActAddCond: begin
          if (used >= psth_pkg::NumConditions) r.status = psth_pkg::StFull;
          else begin
            r.newc = used[3:0];
            registered[used] = 1;
            class_trials[used] = '0;
            used++;
          end
        end
        psth_pkg::ActStart: begin
          if (!registered[w.cl]) begin
            r.status = psth_pkg::StUnreg;
            r.ctrials = class_trials[w.cl];
          end else begin
            cur = w.cl;
            class_ok = 1;
            if (total != psth_pkg::Sat16) total++;
            if (class_trials[w.cl] != psth_pkg::Sat16) class_trials[w.cl]++;
            r.ctrials = class_trials[w.cl];
          end
        end
        psth_pkg::ActAlign: begin
          start = w.t;
          start_ok = 1;
          in_trial = 1;
        end
        psth_pkg::ActEnd: begin
          in_trial = 0;
          class_ok = 0;
          start_ok = 0;
        end
        psth_pkg::ActSpike: begin
          if (!(in_trial && class_ok && start_ok)) r.status = psth_pkg::StNoTrial;
          else begin
            r.ctrials = class_trials[cur];
            if (!registered[cur]) r.status = psth_pkg::StUnreg;
            else if (w.t < start) r.status = psth_pkg::StOutside;
            else begin
              wd = (bin_width == 0) ? 1 : bin_width;
              bin = (w.t - start) / wd;
              if (bin >= bin_limit()) r.status = psth_pkg::StOutside;
              else begin
                key = {w.ch, w.un, cur, bin[5:0]};
                if (!counts.exists(key)) counts[key] = 0;
                if (counts[key] < 65535) counts[key]++;
                hit_cells = {hit_cells, key};
              end
            end
          end
        end
        psth_pkg::ActRead: begin
          r.ctrials = class_trials[w.cl];
          if (!registered[w.cl]) r.status = psth_pkg::StUnreg;
          else if (w.b >= bin_limit()) r.status = psth_pkg::StOutside;
          else begin
            key = {w.ch, w.un, w.cl, w.b};
            r.value = counts.exists(key) ? counts[key][15:0] : 16'd0;
          end
        end
        default: begin
          counts.delete();
          foreach (class_trials[i]) class_trials[i] = '0;
          total = '0;
        end
      endcase
      r.total = total;
      pending_results = {pending_results, r};
    endfunction

    function void check_word(logic [55:0] d);
      psth_result_t e;
      if (pending_results.size() == 0) begin
        $error("result word 0x%h with nothing expected", d);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (d[2:0] !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, d[2:0]);
        errors++;
      end
      if (d[18:3] !== e.value) begin
        $error("bin_value: expected %0d, got %0d", e.value, d[18:3]);
        errors++;
      end
      if (d[34:19] !== e.ctrials) begin
        $error("class_trials_out: expected %0d, got %0d", e.ctrials, d[34:19]);
        errors++;
      end
      if (d[50:35] !== e.total) begin
        $error("total_trials_out: expected %0d, got %0d", e.total, d[50:35]);
        errors++;
      end
      if (d[54:51] !== e.newc) begin
        $error("new_condition: expected %0d, got %0d", e.newc, d[54:51]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [55:0] m_axis_tdata;
  logic        cfg_we_i = 0;
  logic        cfg_addr_i = 0;
  logic [11:0] cfg_wdata_i = '0;

  histogram_model model = new();
  bit          quiet = 0;
  int          stall_left = 0;
  int          words_sent = 0;

  psth_accumulator dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sink side: random back-pressure, checking on each accepted word
  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) quiet <= !quiet;
    if (rst_ni && m_axis_tvalid && m_axis_tready) model.check_word(m_axis_tdata);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 0;
    end else begin
      stall_left <= pick_gap();
      m_axis_tready <= 1;
    end
  end

  task automatic send(psth_pkg::action_e act, logic [31:0] t = '0, logic [3:0] cl = '0,
                      logic [4:0] ch = '0, logic [1:0] un = '0, logic [5:0] b = '0);
    event_word_t w;
    int          gap;
    w = '{act, t, cl, ch, un, b};
    s_axis_tvalid <= 1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {7'd0, b, un, ch, cl, t};
    do @(posedge clk_i); while (!s_axis_tready);
    model.note_word(w);
    words_sent++;
    // tvalid stays high when the next word follows back to back
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // random class, channel, unit and bin fields
  task automatic send_random(psth_pkg::action_e act, logic [31:0] t);
    logic [3:0] cl;
    logic [4:0] ch;
    logic [1:0] un;
    logic [5:0] b;
    cl = 4'($urandom);
    ch = 5'($urandom);
    un = 2'($urandom);
    b  = 6'($urandom);
    send(act, t, cl, ch, un, b);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (model.pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(logic addr, logic [11:0] data);
    cfg_we_i    <= 1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (addr == 1'b0) model.bin_width = data;
    else model.bins_in_use = data[6:0];
    @(posedge clk_i);
  endtask

  task automatic run_trial();
    logic [31:0] t0;
    int unsigned span, wd;
    logic [3:0]  cl;
    int unsigned key;
    if (model.used == 0) send(psth_pkg::ActAddCond);
    if ($urandom_range(0, 9) == 0) send(psth_pkg::ActAddCond);
    cl = ($urandom_range(0, 9) < 9) ? 4'($urandom_range(0, model.used - 1))
                                    : 4'($urandom);
    send(psth_pkg::ActStart, $urandom, cl, 5'($urandom), 2'($urandom), 6'($urandom));
    t0 = $urandom;
    send_random(psth_pkg::ActAlign, t0);
    wd = (model.bin_width == 0) ? 1 : model.bin_width;
    span = wd * model.bin_limit();
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 9) == 0)
        send_random(psth_pkg::ActSpike, $urandom);
      else
        send_random(psth_pkg::ActSpike, t0 + $urandom_range(0, span + span / 5 + 1));
    end
    if ($urandom_range(0, 4) != 0) send_random(psth_pkg::ActEnd, $urandom);
    repeat ($urandom_range(1, 3)) begin
      if (model.hit_cells.size() != 0 && $urandom_range(0, 9) < 7) begin
        key = model.hit_cells[$urandom_range(0, model.hit_cells.size() - 1)];
        send(psth_pkg::ActRead, $urandom, key[9:6], key[16:12], key[11:10], key[5:0]);
      end else
        send_random(psth_pkg::ActRead, $urandom);
    end
  endtask

  task automatic run_noise();
    psth_pkg::action_e act;
    act = psth_pkg::action_e'($urandom_range(1, 6));
    send_random(act, $urandom);
  endtask

  initial begin
    logic [11:0] widths[6];
    logic [11:0] bin_counts[6];
    int          stop_at;
    widths     = '{12'd10, 12'd1, 12'd0, 12'd4095, 12'd3, 12'd37};
    bin_counts = '{12'd50, 12'd64, 12'd0, 12'd127, 12'hF85, 12'd8};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;

    // directed: error paths, table full, wraparound edge of time
    send(psth_pkg::ActSpike, 32'd5);
    send(psth_pkg::ActRead, 32'd0, 4'd0, 5'd0, 2'd0, 6'd0);
    send(psth_pkg::ActRead, 32'hFFFF_FFFF, 4'd15, 5'd31, 2'd3, 6'd63);
    send(psth_pkg::ActStart, 32'd0, 4'd5);
    repeat (17) send(psth_pkg::ActAddCond);
    send(psth_pkg::ActStart, 32'd0, 4'd15);
    send(psth_pkg::ActAlign, 32'hFFFF_FFF0);
    send(psth_pkg::ActSpike, 32'hFFFF_FFFF, 4'd0, 5'd31, 2'd3, 6'd0);
    send(psth_pkg::ActSpike, 32'd0, 4'd0, 5'd0, 2'd0, 6'd0);
    send(psth_pkg::ActRead, 32'd0, 4'd15, 5'd31, 2'd3, 6'd1);
    send(psth_pkg::ActRead, 32'd0, 4'd15, 5'd31, 2'd3, 6'd63);
    send(psth_pkg::ActEnd);
    send(psth_pkg::ActSpike, 32'hFFFF_FFF5, 4'd0, 5'd31, 2'd3, 6'd0);
    send(psth_pkg::ActZero);
    send(psth_pkg::ActRead, 32'd0, 4'd15, 5'd31, 2'd3, 6'd1);
    send(psth_pkg::ActClear);
    send(psth_pkg::ActAddCond);

    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(1'b0, widths[p]);
      write_reg(1'b1, bin_counts[p]);
      stop_at = words_sent + 270;
      while (words_sent < stop_at) begin
        if ($urandom_range(0, 99) < 80) run_trial();
        else run_noise();
      end
      // a sweep is long, so clear and zero are kept rare
      if (p == 2) send(psth_pkg::ActZero);
      if (p == 4) send(psth_pkg::ActClear);
    end
    drain();
    if (model.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
